// ----- design/cemc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster editing move cost: shared package
// Widths, action codes, controller states and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cemc_pkg;

	// Default number of vertex slots, handed to the top level parameter.
	localparam int MAX_VERTICES_DEF = 64;

	// Fixed field widths.
	localparam int VCNT_W   = 7;
	localparam int FIELD_W  = 6;
	localparam int ACTION_W = 3;
	localparam int COST_W   = 11;
	// Signed running cost: stored cost plus or minus one per scanned vertex, or an evaluation's mismatched-pair count.
	localparam int ACC_W    = 13;

	localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

	// Input actions; the two remaining codes do nothing.
	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR    = 3'd0,
		ACT_ADD_EDGE = 3'd1,
		ACT_ASSIGN   = 3'd2,
		ACT_EVALUATE = 3'd3,
		ACT_QUERY    = 3'd4,
		ACT_COMMIT   = 3'd5
	} action_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_EDGE_WR_V,
		ST_EDGE_WR_U,
		ST_MOVE_CHK,
		ST_MOVE_SCAN,
		ST_EVAL_ROW,
		ST_EVAL_LATCH,
		ST_EVAL_SCAN
	} state_t;

	// Read address source for the adjacency and cluster memories.
	typedef enum logic [1:0] {
		ADDR_VERTEX,
		ADDR_OTHER,
		ADDR_ROW,
		ADDR_SCAN
	} addr_sel_t;

	// Which value goes out as a result.
	typedef enum logic [1:0] {
		RES_NONE,
		RES_KEEP,
		RES_MOVE,
		RES_EVAL
	} res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      capture;
		logic      clear;
		logic      edge_wr_v;
		logic      edge_wr_u;
		logic      clu_write;
		logic      acc_clear;
		logic      acc_load_cost;
		logic      latch_row;
		logic      scan;
		logic      scan_move;
		logic      row_next;
		logic      commit;
		addr_sel_t adj_sel;
		addr_sel_t clu_sel;
		res_sel_t  res_sel;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                edge_ok;
		logic                vertex_ok;
		logic                same_cluster;
		logic                row_has_pairs;
		logic                scan_done;
	} dp_status_t;

endpackage

// ----- design/cemc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster editing move cost: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cemc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/cemc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster editing move cost: controller
// Sequences each action through the datapath: edge insertion as two
// read-modify-write steps, move queries as one scan over all vertices and
// full evaluation as one scan per adjacency row.
// ----------------------------------------------------------------------------
module cemc_ctrl import cemc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output logic       busy,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.adj_sel = ADDR_VERTEX;
		cmd.clu_sel = ADDR_VERTEX;
		cmd.res_sel = RES_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				// The reads of the vertex's row and cluster are issued here.
				state_d = ST_IDLE;
				case (status.action)
					ACT_CLEAR: begin
						cmd.clear = 1'b1;
					end
					ACT_ADD_EDGE: begin
						if (status.edge_ok) begin
							state_d = ST_EDGE_WR_V;
						end
					end
					ACT_ASSIGN: begin
						cmd.clu_write = status.vertex_ok;
					end
					ACT_EVALUATE: begin
						cmd.acc_clear = 1'b1;
						state_d       = ST_EVAL_ROW;
					end
					ACT_QUERY, ACT_COMMIT: begin
						if (status.vertex_ok) begin
							state_d = ST_MOVE_CHK;
						end else begin
							cmd.res_sel = RES_KEEP;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_EDGE_WR_V: begin
				cmd.edge_wr_v = 1'b1;
				cmd.adj_sel   = ADDR_OTHER;
				state_d       = ST_EDGE_WR_U;
			end
			ST_EDGE_WR_U: begin
				cmd.edge_wr_u = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_MOVE_CHK: begin
				if (status.same_cluster) begin
					cmd.res_sel = RES_KEEP;
					state_d     = ST_IDLE;
				end else begin
					cmd.latch_row     = 1'b1;
					cmd.scan_move     = 1'b1;
					cmd.acc_load_cost = 1'b1;
					state_d           = ST_MOVE_SCAN;
				end
			end
			ST_MOVE_SCAN: begin
				cmd.scan      = 1'b1;
				cmd.scan_move = 1'b1;
				cmd.clu_sel   = ADDR_SCAN;
				if (status.scan_done) begin
					cmd.res_sel   = RES_MOVE;
					cmd.commit    = (status.action == ACT_COMMIT);
					cmd.clu_write = (status.action == ACT_COMMIT);
					state_d       = ST_IDLE;
				end
			end
			ST_EVAL_ROW: begin
				if (status.row_has_pairs) begin
					cmd.adj_sel = ADDR_ROW;
					cmd.clu_sel = ADDR_ROW;
					state_d     = ST_EVAL_LATCH;
				end else begin
					cmd.res_sel = RES_EVAL;
					state_d     = ST_IDLE;
				end
			end
			ST_EVAL_LATCH: begin
				cmd.latch_row = 1'b1;
				state_d       = ST_EVAL_SCAN;
			end
			ST_EVAL_SCAN: begin
				cmd.scan    = 1'b1;
				cmd.clu_sel = ADDR_SCAN;
				if (status.scan_done) begin
					cmd.row_next = 1'b1;
					state_d      = ST_EVAL_ROW;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/cemc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster editing move cost: datapath
// Adjacency and cluster memories with per-entry valid bits, the vertex
// count register, a two-stage scan (memory read, then accumulate) and the
// result registers.
// ----------------------------------------------------------------------------
module cemc_dp import cemc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [VCNT_W-1:0]   cfg_data,
	input  logic [ACTION_W-1:0] action,
	input  logic [FIELD_W-1:0]  vertex,
	input  logic [FIELD_W-1:0]  other_vertex,
	input  logic [FIELD_W-1:0]  cluster,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	output logic                result_valid,
	output logic [COST_W-1:0]   cost,
	output logic                better
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [VCNT_W-1:0] MAX_CNT = VCNT_W'(MAX_VERTICES);
	localparam logic [COST_W-1:0] COST_CAP =
		COST_W'((MAX_VERTICES * (MAX_VERTICES - 1)) / 2);
	localparam logic signed [ACC_W-1:0] CAP_ACC =
		ACC_W'((MAX_VERTICES * (MAX_VERTICES - 1)) / 2);
	localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1);

	// Captured input item.
	logic [ACTION_W-1:0] action_q;
	logic [FIELD_W-1:0]  vertex_q;
	logic [FIELD_W-1:0]  other_q;
	logic [FIELD_W-1:0]  cluster_q;

	logic [VCNT_W-1:0] vcnt_q;
	logic [VCNT_W-1:0] n_eff;

	// Memories and their valid bits.
	logic [MAX_VERTICES-1:0] adj_vld_q;
	logic [MAX_VERTICES-1:0] clu_vld_q;
	logic                    adj_rvld_q;
	logic                    clu_rvld_q;
	logic [AW-1:0]           adj_raddr;
	logic [AW-1:0]           clu_raddr;
	logic [AW-1:0]           adj_waddr;
	logic [MAX_VERTICES-1:0] adj_wdata;
	logic                    adj_we;
	logic [MAX_VERTICES-1:0] adj_rdata;
	logic [FIELD_W-1:0]      clu_rdata;
	logic [MAX_VERTICES-1:0] adj_rd;
	logic [FIELD_W-1:0]      clu_rd;
	logic [MAX_VERTICES-1:0] bit_u;
	logic [MAX_VERTICES-1:0] bit_v;

	// Scan state.
	logic [MAX_VERTICES-1:0] row_q;
	logic [FIELD_W-1:0]      ci_q;
	logic [CW-1:0]           i_q;
	logic [CW-1:0]           j_q;
	logic [AW-1:0]           j_s1;
	logic                    vld_s1;
	logic                    issue;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term;

	logic [COST_W-1:0] cur_cost_q;
	logic [COST_W-1:0] cand;
	logic              cand_better;

	logic              res_valid_q;
	logic [COST_W-1:0] res_cost_q;
	logic              res_better_q;

	// Input capture; payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			vertex_q  <= vertex;
			other_q   <= other_vertex;
			cluster_q <= cluster;
		end
	end

	// Vertex count register and the count in effect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= VCNT_RESET;
		end else if (cfg_we) begin
			vcnt_q <= cfg_data;
		end
	end

	assign n_eff = (vcnt_q > MAX_CNT) ? MAX_CNT : vcnt_q;

	// Read address selection for both memories.
	always_comb begin
		case (cmd.adj_sel)
			ADDR_OTHER: adj_raddr = other_q[AW-1:0];
			ADDR_ROW:   adj_raddr = i_q[AW-1:0];
			ADDR_SCAN:  adj_raddr = j_q[AW-1:0];
			default:    adj_raddr = vertex_q[AW-1:0];
		endcase
		case (cmd.clu_sel)
			ADDR_OTHER: clu_raddr = other_q[AW-1:0];
			ADDR_ROW:   clu_raddr = i_q[AW-1:0];
			ADDR_SCAN:  clu_raddr = j_q[AW-1:0];
			default:    clu_raddr = vertex_q[AW-1:0];
		endcase
	end

	// Edge insertion writes the vertex's row, then the other endpoint's row.
	assign bit_u     = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << other_q[AW-1:0];
	assign bit_v     = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << vertex_q[AW-1:0];
	assign adj_we    = cmd.edge_wr_v | cmd.edge_wr_u;
	assign adj_waddr = cmd.edge_wr_u ? other_q[AW-1:0] : vertex_q[AW-1:0];
	assign adj_wdata = adj_rd | (cmd.edge_wr_u ? bit_v : bit_u);

	cemc_ram #(
		.WIDTH (MAX_VERTICES),
		.DEPTH (MAX_VERTICES)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	cemc_ram #(
		.WIDTH (FIELD_W),
		.DEPTH (MAX_VERTICES)
	) u_clu_ram (
		.clk   (clk),
		.we    (cmd.clu_write),
		.waddr (vertex_q[AW-1:0]),
		.wdata (cluster_q),
		.raddr (clu_raddr),
		.rdata (clu_rdata)
	);

	// Valid bits: an entry never written since clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_vld_q  <= '0;
			clu_vld_q  <= '0;
			adj_rvld_q <= 1'b0;
			clu_rvld_q <= 1'b0;
		end else begin
			adj_rvld_q <= adj_vld_q[adj_raddr];
			clu_rvld_q <= clu_vld_q[clu_raddr];
			if (cmd.clear) begin
				adj_vld_q <= '0;
				clu_vld_q <= '0;
			end else begin
				if (adj_we) begin
					adj_vld_q[adj_waddr] <= 1'b1;
				end
				if (cmd.clu_write) begin
					clu_vld_q[vertex_q[AW-1:0]] <= 1'b1;
				end
			end
		end
	end

	assign adj_rd = adj_rvld_q ? adj_rdata : '0;
	assign clu_rd = clu_rvld_q ? clu_rdata : '0;

	// Scan issue: one cluster read per cycle up to the vertex count.
	assign issue = cmd.scan && (VCNT_W'(j_q) < n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q[AW-1:0];
		if (cmd.latch_row) begin
			row_q <= adj_rd;
			ci_q  <= clu_rd;
			j_q   <= cmd.scan_move ? '0 : i_q + CW'(1);
		end else if (issue) begin
			j_q <= j_q + CW'(1);
		end
		if (cmd.acc_clear) begin
			i_q <= '0;
		end else if (cmd.row_next) begin
			i_q <= i_q + CW'(1);
		end
	end

	// Per-vertex contribution. A move adds one per neighbour in the old cluster and
	// per non-neighbour in the new one and removes one for the reverse cases; a full
	// evaluation counts each pair whose cluster match disagrees with the edge.
	always_comb begin
		term = '0;
		if (cmd.scan_move) begin
			if (j_s1 != vertex_q[AW-1:0]) begin
				if (clu_rd == ci_q) begin
					term = row_q[j_s1] ? ACC_ONE : -ACC_ONE;
				end else if (clu_rd == cluster_q) begin
					term = row_q[j_s1] ? -ACC_ONE : ACC_ONE;
				end
			end
		end else if ((clu_rd == ci_q) != row_q[j_s1]) begin
			term = ACC_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (cmd.acc_load_cost) begin
			acc_q <= signed'({{(ACC_W-COST_W){1'b0}}, cur_cost_q});
		end else if (vld_s1) begin
			acc_q <= acc_q + term;
		end
	end

	// Saturate the candidate cost into the legal range.
	always_comb begin
		if (acc_q[ACC_W-1]) begin
			cand = '0;
		end else if (acc_q > CAP_ACC) begin
			cand = COST_CAP;
		end else begin
			cand = acc_q[COST_W-1:0];
		end
	end

	assign cand_better = (cand < cur_cost_q);

	// Stored cost and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cost_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (cmd.res_sel != RES_NONE);
			if (cmd.clear) begin
				cur_cost_q <= '0;
			end else if (cmd.res_sel == RES_EVAL) begin
				cur_cost_q <= acc_q[COST_W-1:0];
			end else if ((cmd.res_sel == RES_MOVE) && cmd.commit) begin
				cur_cost_q <= cand;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			RES_KEEP: begin
				res_cost_q   <= cur_cost_q;
				res_better_q <= 1'b0;
			end
			RES_MOVE: begin
				res_cost_q   <= cand;
				res_better_q <= cand_better;
			end
			RES_EVAL: begin
				res_cost_q   <= acc_q[COST_W-1:0];
				res_better_q <= 1'b0;
			end
			default: begin
				res_cost_q   <= res_cost_q;
				res_better_q <= res_better_q;
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign cost         = res_cost_q;
	assign better       = res_better_q;

	// Status to the controller.
	always_comb begin
		status.action        = action_q;
		status.vertex_ok     = ({1'b0, vertex_q} < n_eff);
		status.edge_ok       = ({1'b0, vertex_q} < n_eff) && ({1'b0, other_q} < n_eff) &&
			(vertex_q != other_q);
		status.same_cluster  = (clu_rd == cluster_q);
		status.row_has_pairs = ((VCNT_W'(i_q) + VCNT_W'(1)) < n_eff);
		status.scan_done     = !(VCNT_W'(j_q) < n_eff) && !vld_s1;
	end

endmodule

// ----- design/cluster_edit_move_cost.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster editing move cost: top level
// Adjacency matrix, cluster numbers and editing cost with full evaluation
// and single-vertex move query and commit.
//
// Channel   Signals                                   Transfer
// config    cfg_valid, cfg_ready, cfg_data            cfg_valid && cfg_ready
// command   start, busy, action, vertex,              start && !busy
//           other_vertex, cluster
// result    result_valid, cost, better                result_valid, one cycle
//
// Per command: clear and assign act at dispatch, add edge writes both rows,
// query or commit reads the cluster memory once per vertex (with no scan when
// the vertex already sits in the target cluster or is not in use), and
// evaluate scans one pair per cycle plus row reads (no scan with fewer than
// two vertices). Query, commit and evaluate results appear in the first cycle
// with busy low; a new command may be taken in that same cycle. Reset leaves
// all memories logically zero through valid bits, with no clearing pass.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module cluster_edit_move_cost import cemc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [VCNT_W-1:0]   cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic [ACTION_W-1:0] action,
	input  logic [FIELD_W-1:0]  vertex,
	input  logic [FIELD_W-1:0]  other_vertex,
	input  logic [FIELD_W-1:0]  cluster,
	output logic                result_valid,
	output logic [COST_W-1:0]   cost,
	output logic                better
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// The register is always ready for a transfer.
	assign cfg_ready = 1'b1;

	cemc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	cemc_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_data     (cfg_data),
		.action       (action),
		.vertex       (vertex),
		.other_vertex (other_vertex),
		.cluster      (cluster),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.cost         (cost),
		.better       (better)
	);

endmodule

// ----- design/cemc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster editing move cost: port checker
// Checks command and result timing and the cost range at the top level.
// ----------------------------------------------------------------------------
module cemc_checker import cemc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input logic [COST_W-1:0] cost
);

	localparam logic [COST_W-1:0] COST_LIMIT =
		COST_W'((MAX_VERTICES_DEF * (MAX_VERTICES_DEF - 1)) / 2);

	// An accepted command always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer not followed by busy");

	// Results only come out of work in progress.
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !result_valid)
		else $error("result strobe after an idle cycle");

	// Every reported cost lies within the pair count.
	a_cost_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (cost <= COST_LIMIT))
		else $error("reported cost above the pair count");

endmodule

bind cluster_edit_move_cost cemc_checker u_cemc_checker (.*);
